/* hdl/leja_pkg.sv */
// leja_pkg: shared constants, handshake structs and double-precision helpers
// for the Leja point selector; used by leja_fsub, leja_fmul and the top level
// depends on nothing
package leja_pkg;

    localparam logic [63:0] ONE_BITS         = 64'h3FF0000000000000;
    localparam logic [63:0] NORMAL_MIN_BITS  = 64'h0010000000000000;
    localparam logic [63:0] CLOSE_LIMIT_BITS = 64'h3DDB7CDFD9D7BDBB;
    localparam logic [63:0] QNAN_BITS        = 64'h7FF8000000000000;
    localparam logic [63:0] INF_BITS         = 64'h7FF0000000000000;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_GENERATE = 1'b1;

    localparam logic REG_SEQ_LENGTH = 1'b0;
    localparam logic REG_GRID_COUNT = 1'b1;

    localparam logic [6:0]  SEQ_LENGTH_RESET = 7'd16;
    localparam logic [14:0] GRID_COUNT_RESET = 15'd10001;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } fp_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } fp_rsp_t;

    function automatic logic is_nan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] x);
        return x[62:0] == 63'd0;
    endfunction

    // leading zeros of a byte, 8 when all clear
    function automatic logic [3:0] lz8(input logic [7:0] x);
        logic [3:0] n;
        n = 4'd8;
        for (int j = 0; j < 8; j++) begin
            if (x[j]) begin
                n = 4'(7 - j);
            end
        end
        return n;
    endfunction

    // round to nearest even and pack a positive result, exponent at least 1
    function automatic logic [63:0] round_pack(input logic [52:0] keep, input logic g,
                                               input logic s, input logic signed [12:0] e);
        logic [53:0]        r;
        logic [52:0]        m;
        logic signed [12:0] ef;
        r = {1'b0, keep} + 54'(g & (s | keep[0]));
        if (r[53]) begin
            m  = r[53:1];
            ef = e + 13'sd1;
        end else begin
            m  = r[52:0];
            ef = e;
        end
        if (ef >= 13'sd2047) begin
            return INF_BITS;
        end
        return {1'b0, (m[52] ? ef[10:0] : 11'd0), m[51:0]};
    endfunction

endpackage

/* hdl/leja_ram.sv */
// leja_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module leja_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/leja_fsub.sv */
// leja_fsub: multi-cycle double subtract, returns the magnitude of a - b
// round to nearest even; depends on leja_pkg
module leja_fsub (
    input  logic              clk,
    input  logic              rst_n,
    input  leja_pkg::fp_req_t req,
    output leja_pkg::fp_rsp_t rsp
);
    import leja_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALIGN = 5'b00010,
        S_ADD   = 5'b00100,
        S_NORM  = 5'b01000,
        S_ROUND = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic        done_reg;
    logic [63:0] res_reg;
    logic        special_reg;
    logic [63:0] special_val_reg;
    logic        eff_sub_reg;
    logic [10:0] e_big_reg, e_small_reg;
    logic [52:0] m_big_reg, m_small_reg;
    logic [55:0] b_al_reg;
    logic [55:0] sum_reg;
    logic [11:0] e_reg;

    logic [62:0] a_mag, b_mag, big, small_mag;
    logic        a_big;
    logic        spec;
    logic [63:0] spec_val;
    logic [10:0] d;
    logic [55:0] b_ext, b_al;
    logic [56:0] sum57;
    logic [3:0]  lz, sh;
    logic [11:0] lim;

    always_comb
    begin
        a_mag     = req.a[62:0];
        b_mag     = req.b[62:0];
        a_big     = a_mag >= b_mag;
        big       = a_big ? a_mag : b_mag;
        small_mag = a_big ? b_mag : a_mag;
        spec      = 1'b1;
        spec_val  = 64'd0;
        if (is_nan(req.a) || is_nan(req.b))
        begin
            spec_val = QNAN_BITS;
        end else if (is_inf(req.a) && is_inf(req.b))
        begin
            // same signs cancel into a nan
            spec_val = (req.a[63] == req.b[63]) ? QNAN_BITS : INF_BITS;
        end else if (is_inf(req.a) || is_inf(req.b))
        begin
            spec_val = INF_BITS;
        end else
        begin
            spec = 1'b0;
        end
    end

    // alignment of the smaller operand with sticky, the add or subtract and the normalize shift amount
    always_comb
    begin
        d     = e_big_reg - e_small_reg;
        b_ext = {m_small_reg, 3'b000};
        if (d >= 11'd56)
        begin
            b_al = {55'd0, |m_small_reg};
        end else
        begin
            b_al = (b_ext >> d) | 56'(|(b_ext & ~({56{1'b1}} << d)));
        end
        if (eff_sub_reg)
        begin
            sum57 = {1'b0, m_big_reg, 3'b000} - {1'b0, b_al_reg};
        end else
        begin
            sum57 = {1'b0, m_big_reg, 3'b000} + {1'b0, b_al_reg};
        end
        lz  = lz8(sum_reg[55:48]);
        lim = e_reg - 12'd1;
        sh  = (12'(lz) > lim) ? lim[3:0] : lz;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req.start) state_next = spec ? S_ROUND : S_ALIGN;
            S_ALIGN: state_next = S_ADD;
            S_ADD:   state_next = S_NORM;
            S_NORM:  if (sum_reg[55] || e_reg <= 12'd1) state_next = S_ROUND;
            S_ROUND: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_ROUND);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                special_reg     <= spec;
                special_val_reg <= spec_val;
                eff_sub_reg     <= (req.a[63] == req.b[63]);
                e_big_reg       <= (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
                m_big_reg       <= {big[62:52] != 11'd0, big[51:0]};
                e_small_reg     <= (small_mag[62:52] == 11'd0) ? 11'd1 : small_mag[62:52];
                m_small_reg     <= {small_mag[62:52] != 11'd0, small_mag[51:0]};
            end
            S_ALIGN: b_al_reg <= b_al;
            S_ADD:
            begin
                if (sum57[56])
                begin
                    sum_reg <= {sum57[56:2], sum57[1] | sum57[0]};
                    e_reg   <= {1'b0, e_big_reg} + 12'd1;
                end else
                begin
                    sum_reg <= sum57[55:0];
                    e_reg   <= {1'b0, e_big_reg};
                end
            end
            S_NORM:
            begin
                if (!(sum_reg[55] || e_reg <= 12'd1))
                begin
                    sum_reg <= sum_reg << sh;
                    e_reg   <= e_reg - 12'(sh);
                end
            end
            S_ROUND:
            begin
                res_reg <= special_reg ? special_val_reg
                         : round_pack(sum_reg[55:3], sum_reg[2], |sum_reg[1:0],
                                      $signed({1'b0, e_reg}));
            end
            default: ;
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;
endmodule

/* hdl/leja_fmul.sv */
// leja_fmul: multi-cycle double multiply of magnitudes, one 27x27 partial
// product a cycle; round to nearest even; depends on leja_pkg
module leja_fmul (
    input  logic              clk,
    input  logic              rst_n,
    input  leja_pkg::fp_req_t req,
    output leja_pkg::fp_rsp_t rsp
);
    import leja_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_NORM  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_ROUND = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic               done_reg;
    logic [63:0]        res_reg;
    logic               special_reg;
    logic [63:0]        special_val_reg;
    logic [52:0]        ma_reg, mb_reg;
    logic [1:0]         cnt_reg;
    logic [105:0]       acc_reg;
    logic signed [12:0] e_reg;

    logic               spec;
    logic [63:0]        spec_val;
    logic [10:0]        ea, eb;
    logic [26:0]        a_part, b_part;
    logic [53:0]        pp;
    logic [105:0]       pp_sh;
    logic [3:0]         lz, sh;
    logic signed [12:0] lim;
    logic [12:0]        rs_full;
    logic [6:0]         rs;
    logic [105:0]       shifted;

    always_comb
    begin
        spec     = 1'b1;
        spec_val = 64'd0;
        if (is_nan(req.a) || is_nan(req.b))
        begin
            spec_val = QNAN_BITS;
        end else if ((is_inf(req.a) && is_zero(req.b)) || (is_zero(req.a) && is_inf(req.b)))
        begin
            spec_val = QNAN_BITS;
        end else if (is_inf(req.a) || is_inf(req.b))
        begin
            spec_val = INF_BITS;
        end else if (is_zero(req.a) || is_zero(req.b))
        begin
            spec_val = 64'd0;
        end else
        begin
            spec = 1'b0;
        end
        ea = (req.a[62:52] == 11'd0) ? 11'd1 : req.a[62:52];
        eb = (req.b[62:52] == 11'd0) ? 11'd1 : req.b[62:52];
    end

    always_comb
    begin
        a_part = cnt_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        b_part = cnt_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        pp     = 54'(a_part) * 54'(b_part);
        case (cnt_reg)
            2'd0:    pp_sh = 106'(pp);
            2'd3:    pp_sh = 106'(pp) << 54;
            default: pp_sh = 106'(pp) << 27;
        endcase
        lz  = lz8(acc_reg[105:98]);
        lim = e_reg - 13'sd1;
        sh  = ($signed({9'd0, lz}) > lim) ? lim[3:0] : lz;
        // right shift into the subnormal range
        rs_full = 13'(13'sd1 - e_reg);
        rs      = (rs_full > 13'd127) ? 7'd127 : rs_full[6:0];
        shifted = (acc_reg >> rs) | 106'(|(acc_reg & ~({106{1'b1}} << rs)));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req.start) state_next = spec ? S_ROUND : S_MUL;
            S_MUL:   if (cnt_reg == 2'd3) state_next = S_NORM;
            S_NORM:  if (acc_reg[105] || e_reg <= 13'sd1) state_next = S_SHIFT;
            S_SHIFT: state_next = S_ROUND;
            S_ROUND: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
        end else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_ROUND);
            if (state_reg == S_MUL)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end else
            begin
                cnt_reg <= 2'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                special_reg     <= spec;
                special_val_reg <= spec_val;
                ma_reg  <= {req.a[62:52] != 11'd0, req.a[51:0]};
                mb_reg  <= {req.b[62:52] != 11'd0, req.b[51:0]};
                e_reg   <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 13'sd1022;
                acc_reg <= '0;
            end
            S_MUL: acc_reg <= acc_reg + pp_sh;
            S_NORM:
            begin
                if (!(acc_reg[105] || e_reg <= 13'sd1))
                begin
                    acc_reg <= acc_reg << sh;
                    e_reg   <= e_reg - $signed({9'd0, sh});
                end
            end
            S_SHIFT:
            begin
                if (e_reg < 13'sd1)
                begin
                    acc_reg <= shifted;
                    e_reg   <= 13'sd1;
                end
            end
            S_ROUND:
            begin
                res_reg <= special_reg ? special_val_reg
                         : round_pack(acc_reg[105:53], acc_reg[52], |acc_reg[51:0], e_reg);
            end
            default: ;
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;
endmodule

/* hdl/leja_point_selector_unit.sv */
// leja_point_selector_unit: discrete Leja sequence builder over a grid memory
// load beat: taken back to back. generate beat: point 0 is emitted via S_EMIT after accept;
// point p scans grid_count candidates, each against chosen points 0 to p-1 with one subtract
// and one multiply per chosen point, a close difference ending the candidate early
// input is blocked until the last beat of a run enters the output register; output stalls hold the walk
// reset clears control and output valid, loads seq_length 16 and grid_count 10001
module leja_point_selector_unit #(
    parameter int GRID_DEPTH = 16384,
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [13:0] grid_index,
    input  logic [63:0] grid_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  point_index,
    output logic [63:0] point_value,
    output logic        no_candidate,
    output logic        last
);
    import leja_pkg::*;

    localparam int AW  = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int CW  = ($clog2(GRID_DEPTH + 1) > 15) ? $clog2(GRID_DEPTH + 1) : 15;
    localparam int CAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_EMIT      = 11'b00000000010,
        S_SCAN      = 11'b00000000100,
        S_GRID_RD   = 11'b00000001000,
        S_LOAD_CAND = 11'b00000010000,
        S_CH_RD     = 11'b00000100000,
        S_SUB_START = 11'b00001000000,
        S_SUB_WAIT  = 11'b00010000000,
        S_MUL_WAIT  = 11'b00100000000,
        S_CAND_END  = 11'b01000000000,
        S_PT_DONE   = 11'b10000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  seq_length_reg;
    logic [14:0] grid_count_reg;
    logic [6:0]  n_reg, p_reg, i_reg;
    logic [CW-1:0] gc_reg, k_reg;
    logic [63:0] cand_reg, prod_reg, best_reg, best_val_reg;
    logic        close_reg, found_reg;
    logic [63:0] pend_value_reg;
    logic        pend_nc_reg, pend_last_reg;
    logic        out_valid_reg;
    logic [5:0]  out_index_reg;
    logic [63:0] out_value_reg;
    logic        out_nc_reg, out_last_reg;

    logic [6:0]    n_eff;
    logic [CW-1:0] gc_eff;
    logic          accept, gen_accept, grid_we, out_free, close_hit;
    logic [AW-1:0] grid_waddr;
    logic [63:0]   grid_rdata, chosen_rdata, chosen_wdata;
    logic          chosen_we;
    logic [CAW-1:0] chosen_waddr;
    fp_req_t       sub_req, mul_req;
    fp_rsp_t       sub_rsp, mul_rsp;

    assign accept     = in_valid && in_ready;
    assign gen_accept = accept && (cmd == CMD_GENERATE);
    assign grid_we    = accept && (cmd == CMD_LOAD) && (CW'(grid_index) < CW'(GRID_DEPTH));
    assign grid_waddr = AW'(grid_index);
    assign out_free   = !out_valid_reg || out_ready;
    assign close_hit  = sub_rsp.value <= CLOSE_LIMIT_BITS;

    always_comb
    begin
        if (seq_length_reg == 7'd0)
        begin
            n_eff = 7'd1;
        end else if (seq_length_reg > 7'(MAX_POINTS))
        begin
            n_eff = 7'(MAX_POINTS);
        end else
        begin
            n_eff = seq_length_reg;
        end
        gc_eff = (CW'(grid_count_reg) > CW'(GRID_DEPTH)) ? CW'(GRID_DEPTH)
                                                          : CW'(grid_count_reg);
    end

    always_comb
    begin
        chosen_we    = 1'b0;
        chosen_waddr = '0;
        chosen_wdata = ONE_BITS;
        if (state_reg == S_IDLE)
        begin
            chosen_we = gen_accept;
        end else if (state_reg == S_PT_DONE)
        begin
            chosen_we    = found_reg;
            chosen_waddr = p_reg[CAW-1:0];
            chosen_wdata = best_val_reg;
        end
    end

    leja_ram #(.WIDTH(64), .DEPTH(GRID_DEPTH)) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_value),
        .raddr (k_reg[AW-1:0]),
        .rdata (grid_rdata)
    );

    leja_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_chosen_ram (
        .clk   (clk),
        .we    (chosen_we),
        .waddr (chosen_waddr),
        .wdata (chosen_wdata),
        .raddr (i_reg[CAW-1:0]),
        .rdata (chosen_rdata)
    );

    assign sub_req.start = (state_reg == S_SUB_START);
    assign sub_req.a     = cand_reg;
    assign sub_req.b     = chosen_rdata;
    assign mul_req.start = (state_reg == S_SUB_WAIT) && sub_rsp.done && !close_hit;
    assign mul_req.a     = prod_reg;
    assign mul_req.b     = sub_rsp.value;

    leja_fsub u_fsub (.clk(clk), .rst_n(rst_n), .req(sub_req), .rsp(sub_rsp));
    leja_fmul u_fmul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (gen_accept) state_next = S_EMIT;
            S_EMIT:      if (out_free) state_next = pend_last_reg ? S_IDLE : S_SCAN;
            S_SCAN:      state_next = (gc_reg == '0) ? S_PT_DONE : S_GRID_RD;
            S_GRID_RD:   state_next = S_LOAD_CAND;
            S_LOAD_CAND: state_next = S_CH_RD;
            S_CH_RD:     state_next = S_SUB_START;
            S_SUB_START: state_next = S_SUB_WAIT;
            S_SUB_WAIT:  if (sub_rsp.done) state_next = close_hit ? S_CAND_END : S_MUL_WAIT;
            S_MUL_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = (i_reg + 7'd1 == p_reg) ? S_CAND_END : S_CH_RD;
                end
            end
            S_CAND_END:  state_next = (k_reg + CW'(1) == gc_reg) ? S_PT_DONE : S_GRID_RD;
            S_PT_DONE:   state_next = S_EMIT;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seq_length_reg <= SEQ_LENGTH_RESET;
            grid_count_reg <= GRID_COUNT_RESET;
            out_valid_reg  <= 1'b0;
            n_reg          <= 7'd1;
            p_reg          <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            gc_reg         <= '0;
            close_reg      <= 1'b0;
            found_reg      <= 1'b0;
            pend_last_reg  <= 1'b0;
            pend_nc_reg    <= 1'b0;
        end else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SEQ_LENGTH: seq_length_reg <= cfg_data[6:0];
                    REG_GRID_COUNT: grid_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready && !(state_reg == S_EMIT && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (gen_accept)
                    begin
                        n_reg         <= n_eff;
                        gc_reg        <= gc_eff;
                        p_reg         <= '0;
                        pend_nc_reg   <= 1'b0;
                        pend_last_reg <= (n_eff == 7'd1);
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (!pend_last_reg)
                        begin
                            p_reg <= p_reg + 7'd1;
                        end
                    end
                end
                S_SCAN:
                begin
                    found_reg <= 1'b0;
                    k_reg     <= '0;
                end
                S_LOAD_CAND:
                begin
                    close_reg <= 1'b0;
                    i_reg     <= '0;
                end
                S_SUB_WAIT:
                begin
                    if (sub_rsp.done && close_hit)
                    begin
                        close_reg <= 1'b1;
                    end
                end
                S_MUL_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        i_reg <= i_reg + 7'd1;
                    end
                end
                S_CAND_END:
                begin
                    if (!close_reg && !is_nan(prod_reg) && prod_reg > best_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    k_reg <= k_reg + CW'(1);
                end
                S_PT_DONE:
                begin
                    pend_nc_reg   <= !found_reg;
                    pend_last_reg <= !found_reg || (p_reg + 7'd1 == n_reg);
                end
                default: ;
            endcase
        end
    end

    // payload side
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:      pend_value_reg <= ONE_BITS;
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_index_reg <= p_reg[5:0];
                    out_value_reg <= pend_value_reg;
                    out_nc_reg    <= pend_nc_reg;
                    out_last_reg  <= pend_last_reg;
                end
            end
            S_SCAN:      best_reg <= NORMAL_MIN_BITS;
            S_LOAD_CAND:
            begin
                cand_reg <= grid_rdata;
                prod_reg <= ONE_BITS;
            end
            S_MUL_WAIT:  if (mul_rsp.done) prod_reg <= mul_rsp.value;
            S_CAND_END:
            begin
                if (!close_reg && !is_nan(prod_reg) && prod_reg > best_reg)
                begin
                    best_reg     <= prod_reg;
                    best_val_reg <= cand_reg;
                end
            end
            S_PT_DONE:   pend_value_reg <= found_reg ? best_val_reg : 64'd0;
            default: ;
        endcase
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign point_index  = out_index_reg;
    assign point_value  = out_value_reg;
    assign no_candidate = out_nc_reg;
    assign last         = out_last_reg;

    a_nc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_candidate) |-> last)
        else $error("no-candidate beat without last");

    a_nc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_candidate) |-> (point_value == 64'd0))
        else $error("no-candidate beat with nonzero value");

    a_p_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_EMIT) |-> (p_reg < n_reg))
        else $error("point counter beyond sequence length");

    a_sub_done: assert property (@(posedge clk) disable iff (!rst_n)
        sub_rsp.done |-> (state_reg == S_SUB_WAIT))
        else $error("subtract result outside its wait state");

    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_MUL_WAIT))
        else $error("multiply result outside its wait state");
endmodule
